>>> design/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the button press classifier
// Word layouts of both channels, event codes, register indexes and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int NOW_WIDTH       = 32;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } press_ev_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LONG_PRESS   = 2'd0,
        REG_DOUBLE_PRESS = 2'd1,
        REG_BOOT_IGNORE  = 2'd2
    } cfg_index_t;

    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST   = 16'd1500;
    localparam logic [CFG_WIDTH-1:0] DOUBLE_PRESS_RST = 16'd300;
    localparam logic [CFG_WIDTH-1:0] BOOT_IGNORE_RST  = 16'd250;

    typedef struct packed {
        logic [NOW_WIDTH-1:0] now_ms;
        logic                 button_level;
    } in_word_t;

    typedef struct packed {
        logic       power_enable;
        logic [1:0] press_event;
    } out_word_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] long_press_ms;
        logic [CFG_WIDTH-1:0] double_press_ms;
        logic [CFG_WIDTH-1:0] boot_ignore_ms;
    } cfg_t;

endpackage

>>> design/bpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpc_cfg_regs: configuration register file
// Three 16-bit timing registers written through a valid/ready port.
// ----------------------------------------------------------------------------
module bpc_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bpc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [bpc_pkg::CFG_WIDTH-1:0]        cfg_data,
    output bpc_pkg::cfg_t                        cfg
);

    bpc_pkg::cfg_t cfg_reg;
    bpc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                bpc_pkg::REG_LONG_PRESS:   cfg_next.long_press_ms   = cfg_data;
                bpc_pkg::REG_DOUBLE_PRESS: cfg_next.double_press_ms = cfg_data;
                bpc_pkg::REG_BOOT_IGNORE:  cfg_next.boot_ignore_ms  = cfg_data;
                default:                   cfg_next = cfg_reg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ms   <= bpc_pkg::LONG_PRESS_RST;
            cfg_reg.double_press_ms <= bpc_pkg::DOUBLE_PRESS_RST;
            cfg_reg.boot_ignore_ms  <= bpc_pkg::BOOT_IGNORE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/bpc_core.sv
// ----------------------------------------------------------------------------
// bpc_core: press tracking state and classification
// Holds the press/release state and works out one result per sample.
// ----------------------------------------------------------------------------
module bpc_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  bpc_pkg::in_word_t   item,
    input  bpc_pkg::cfg_t       cfg,
    output bpc_pkg::out_word_t  result
);

    localparam int TW = TIME_WIDTH;

    logic          started_reg,        started_next;
    logic [TW-1:0] ignore_end_reg,     ignore_end_next;
    logic          held_down_reg,      held_down_next;
    logic [TW-1:0] press_start_reg,    press_start_next;
    logic [TW-1:0] release_time_reg,   release_time_next;
    logic          pending_single_reg, pending_single_next;
    logic          powered_off_reg,    powered_off_next;

    logic [TW-1:0]      now_w;
    logic [TW-1:0]      ignore_end_eff;
    logic [TW-1:0]      hold_time;
    logic [TW-1:0]      since_release;
    logic               pressed;
    logic               check_single;
    bpc_pkg::press_ev_t ev;

    assign now_w          = TW'(item.now_ms);
    assign pressed        = ~item.button_level;
    assign ignore_end_eff = started_reg ? ignore_end_reg
                                        : now_w + TW'(cfg.boot_ignore_ms);
    assign hold_time      = now_w - press_start_reg;
    assign since_release  = now_w - release_time_reg;

    always_comb begin
        started_next        = 1'b1;
        ignore_end_next     = ignore_end_eff;
        held_down_next      = held_down_reg;
        press_start_next    = press_start_reg;
        release_time_next   = release_time_reg;
        pending_single_next = pending_single_reg;
        powered_off_next    = powered_off_reg;
        check_single        = 1'b1;
        ev                  = bpc_pkg::EV_NONE;

        if (now_w >= ignore_end_eff) begin
            if (pressed && !held_down_reg) begin
                held_down_next   = 1'b1;
                press_start_next = now_w;
            end
            if (!pressed && held_down_reg) begin
                held_down_next = 1'b0;
                if (hold_time >= TW'(cfg.long_press_ms)) begin
                    ev                  = bpc_pkg::EV_LONG;
                    powered_off_next    = 1'b1;
                    pending_single_next = 1'b0;
                    check_single        = 1'b0;
                end else if (!pending_single_reg) begin
                    pending_single_next = 1'b1;
                    release_time_next   = now_w;
                end else begin
                    pending_single_next = 1'b0;
                    ev                  = bpc_pkg::EV_DOUBLE;
                end
            end
            // a release this step either starts a new pending single or ends the
            // old one, so only an older pending release can time out here
            if (check_single && pending_single_reg && pending_single_next &&
                since_release > TW'(cfg.double_press_ms)) begin
                pending_single_next = 1'b0;
                ev                  = bpc_pkg::EV_SINGLE;
            end
        end

        result.power_enable = ~powered_off_next;
        result.press_event  = ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg        <= 1'b0;
            ignore_end_reg     <= '0;
            held_down_reg      <= 1'b0;
            press_start_reg    <= '0;
            release_time_reg   <= '0;
            pending_single_reg <= 1'b0;
            powered_off_reg    <= 1'b0;
        end else if (advance) begin
            started_reg        <= started_next;
            ignore_end_reg     <= ignore_end_next;
            held_down_reg      <= held_down_next;
            press_start_reg    <= press_start_next;
            release_time_reg   <= release_time_next;
            pending_single_reg <= pending_single_next;
            powered_off_reg    <= powered_off_next;
        end
    end

endmodule

>>> design/button_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_press_classifier_unit: single/double/long press detector
// Classifies polled samples of an active-low power button and drives the
// power latch enable.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one word per poll, a millisecond timestamp (wrapping) and
//   the raw pin level (0 = pressed). m_* channel: one word back for every
//   input word, with the power latch drive and the press event code
//   (none, single, double, long). cfg_* channel: register writes, index 0
//   long press time, 1 double press window, 2 boot ignore time; unknown
//   indexes are dropped. Write configuration only while the block is idle.
//   Timing: a word is captured in the input register, classified in one
//   pass of compare/subtract logic and stored in the result register,
//   which drives m_*.
//   Throughput is one word per cycle while m_ready stays high; the input
//   register advances in the same cycle that the result register frees up.
//   Stall: while m_ready is low the result holds, the input register keeps
//   one more word, and s_ready drops once both are full.
//   Reset (synchronous, aresetn low): both registers empty, tracking state
//   cleared, power enable high again, timing registers back to defaults.
// ----------------------------------------------------------------------------
module button_press_classifier_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bpc_pkg::in_word_t                   s_data,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output bpc_pkg::out_word_t                  m_data,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bpc_pkg::CFG_WIDTH-1:0]       cfg_data
);

    bpc_pkg::cfg_t      cfg;
    bpc_pkg::in_word_t  in_word_reg;
    logic               in_valid_reg;
    bpc_pkg::out_word_t out_word_reg;
    logic               out_valid_reg;
    bpc_pkg::out_word_t result;
    logic               advance;

    // Advance the captured word whenever the result register is empty or
    // being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    bpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpc_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_word_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Input register: take a new word whenever there is room.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // Result register: load on advance, hold while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= result;
        end
    end

endmodule

>>> design/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker: port-level checks of the button press classifier
// Watches the result channel for stalls, reset behavior and power-off.
// ----------------------------------------------------------------------------
module bpc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input bpc_pkg::out_word_t m_data
);

    // a stalled word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // nothing shows right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // a long press always drops power
    a_long_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.press_event == bpc_pkg::EV_LONG |-> !m_data.power_enable)
        else $error("long press reported with power still on");

    // power off is sticky across words
    a_off_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.power_enable |=> !m_valid || !m_data.power_enable)
        else $error("power enable rose again without reset");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
